FILE: rtl/assert_macros.svh
// Assertion macros for the RTL; hlg_core.sv is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// A property with an implication that holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`endif

FILE: rtl/hlg_pkg.sv
`timescale 1ns / 1ps

package hlg_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 56;

    typedef enum logic [2:0] {
        REG_START_DELAY = 3'd0,
        REG_UP_QUEUE    = 3'd1,
        REG_DOWN_QUEUE  = 3'd2,
        REG_UP_TIME     = 3'd3,
        REG_DOWN_TIME   = 3'd4,
        REG_PAUSE       = 3'd5,
        REG_SCREEN_OFF  = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_POLL       = 3'd0,
        OP_SCREEN_OFF = 3'd1,
        OP_SCREEN_ON  = 3'd2,
        OP_DISABLE    = 3'd3,
        OP_ENABLE     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_IDLE     = 2'd1,
        MODE_DOWN     = 2'd2,
        MODE_UP       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_UP    = 2'd1,
        ACT_DOWN  = 2'd2,
        ACT_PAUSE = 2'd3
    } act_t;

    typedef struct packed {
        logic [19:0] start_delay_ms;
        logic [9:0]  up_queue_threshold;
        logic [9:0]  down_queue_threshold;
        logic [15:0] up_time_threshold;
        logic [15:0] down_time_threshold;
        logic [15:0] pause_ms;
        logic        screen_off_single_core;
    } cfg_t;

    localparam logic [19:0] RST_START_DELAY = 20'd70000;
    localparam logic [9:0]  RST_UP_QUEUE    = 10'd35;
    localparam logic [9:0]  RST_DOWN_QUEUE  = 10'd5;
    localparam logic [15:0] RST_UP_TIME     = 16'd250;
    localparam logic [15:0] RST_DOWN_TIME   = 16'd250;
    localparam logic [15:0] RST_PAUSE       = 16'd10000;
    localparam logic        RST_SCREEN_OFF  = 1'b1;

endpackage

FILE: rtl/hlg_cfg_regs.sv
`timescale 1ns / 1ps

module hlg_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hlg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hlg_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hlg_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output hlg_pkg::cfg_t                    cfg
);
    import hlg_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_delay_ms         <= RST_START_DELAY;
            cfg_reg.up_queue_threshold     <= RST_UP_QUEUE;
            cfg_reg.down_queue_threshold   <= RST_DOWN_QUEUE;
            cfg_reg.up_time_threshold      <= RST_UP_TIME;
            cfg_reg.down_time_threshold    <= RST_DOWN_TIME;
            cfg_reg.pause_ms               <= RST_PAUSE;
            cfg_reg.screen_off_single_core <= RST_SCREEN_OFF;
        end else if (wr_en) begin
            case (idx)
                REG_START_DELAY: cfg_reg.start_delay_ms       <= pwdata[19:0];
                REG_UP_QUEUE:    cfg_reg.up_queue_threshold   <= pwdata[9:0];
                REG_DOWN_QUEUE:  cfg_reg.down_queue_threshold <= pwdata[9:0];
                REG_UP_TIME:     cfg_reg.up_time_threshold    <= pwdata[15:0];
                REG_DOWN_TIME:   cfg_reg.down_time_threshold  <= pwdata[15:0];
                REG_PAUSE:       cfg_reg.pause_ms             <= pwdata[15:0];
                REG_SCREEN_OFF:  cfg_reg.screen_off_single_core <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START_DELAY: prdata = {12'd0, cfg_reg.start_delay_ms};
            REG_UP_QUEUE:    prdata = {22'd0, cfg_reg.up_queue_threshold};
            REG_DOWN_QUEUE:  prdata = {22'd0, cfg_reg.down_queue_threshold};
            REG_UP_TIME:     prdata = {16'd0, cfg_reg.up_time_threshold};
            REG_DOWN_TIME:   prdata = {16'd0, cfg_reg.down_time_threshold};
            REG_PAUSE:       prdata = {16'd0, cfg_reg.pause_ms};
            REG_SCREEN_OFF:  prdata = {31'd0, cfg_reg.screen_off_single_core};
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/hlg_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hlg_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hlg_pkg::cfg_t                   cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hlg_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [hlg_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hlg_pkg::M_TDATA_W-1:0]   m_tdata
);
    import hlg_pkg::*;

    // Input stage.
    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic [31:0] in_now_reg;
    logic [9:0]  in_depth_reg;
    logic        in_online_reg;

    // Governor state.
    mode_t       mode_reg, mode_next;
    logic        first_reg, first_next;
    logic [31:0] dwell_reg, dwell_next;
    logic [31:0] last_reg, last_next;
    logic        believed_reg, believed_next;
    logic [31:0] since_reg, since_next;
    logic        screen_reg, screen_next;
    logic        resync_reg, resync_next;

    // Result stage.
    logic        out_valid_reg;
    mode_t       out_decision_reg;
    act_t        out_action_reg;
    logic [15:0] out_pause_reg;
    logic [31:0] out_dur_reg;

    act_t        act_next;
    logic [15:0] pause_next;
    logic [31:0] dur_next;

    logic        out_free;
    logic        adv;

    assign out_free = !out_valid_reg || m_tready;
    assign adv      = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_dur_reg, out_pause_reg, out_action_reg, out_decision_reg};

    always_comb begin
        logic        bel;
        logic [31:0] elapsed;
        logic [32:0] sum;
        logic [31:0] dwell_acc;

        mode_next     = mode_reg;
        first_next    = first_reg;
        dwell_next    = dwell_reg;
        last_next     = last_reg;
        believed_next = believed_reg;
        since_next    = since_reg;
        screen_next   = screen_reg;
        resync_next   = resync_reg;
        act_next      = ACT_NONE;
        pause_next    = '0;
        dur_next      = '0;
        bel           = believed_reg;
        elapsed       = '0;
        sum           = '0;
        dwell_acc     = dwell_reg;

        case (in_op_reg)
            OP_POLL: begin
                if (!screen_reg) begin
                    if (resync_reg) begin
                        bel = in_online_reg;
                    end
                    resync_next = 1'b0;
                    if (mode_reg == MODE_DISABLED) begin
                        mode_next = MODE_DISABLED;
                    end else if (in_now_reg <= {12'd0, cfg.start_delay_ms}) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        first_next = 1'b0;
                        elapsed    = first_reg ? 32'd0 : in_now_reg - last_reg;
                        sum        = {1'b0, dwell_reg} + {1'b0, elapsed};
                        dwell_acc  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        dwell_next = dwell_acc;
                        mode_next  = MODE_IDLE;
                        if (!in_online_reg && in_depth_reg >= cfg.up_queue_threshold) begin
                            if (dwell_acc >= {16'd0, cfg.up_time_threshold}) begin
                                mode_next = MODE_UP;
                            end
                        end else if (in_depth_reg <=
                                     (in_online_reg ? cfg.down_queue_threshold : 10'd0)) begin
                            if (dwell_acc >=
                                (in_online_reg ? {16'd0, cfg.down_time_threshold} : 32'd0)) begin
                                mode_next = MODE_DOWN;
                            end
                        end else begin
                            dwell_next = '0;
                        end
                        if (mode_next != MODE_IDLE) begin
                            dwell_next = '0;
                        end
                        last_next = in_now_reg;
                    end
                    believed_next = bel;
                    if (mode_next == MODE_DOWN) begin
                        if (bel && in_online_reg) begin
                            act_next      = ACT_DOWN;
                            believed_next = 1'b0;
                            dur_next      = in_now_reg - since_reg;
                        end else if (bel != in_online_reg) begin
                            act_next    = ACT_PAUSE;
                            pause_next  = cfg.pause_ms;
                            resync_next = 1'b1;
                        end
                    end else if (mode_next == MODE_UP) begin
                        if (!bel && !in_online_reg) begin
                            act_next      = ACT_UP;
                            believed_next = 1'b1;
                            since_next    = in_now_reg;
                        end else if (bel != in_online_reg) begin
                            act_next    = ACT_PAUSE;
                            pause_next  = cfg.pause_ms;
                            resync_next = 1'b1;
                        end
                    end
                end
            end
            OP_SCREEN_OFF: begin
                if (in_online_reg && cfg.screen_off_single_core) begin
                    act_next      = ACT_DOWN;
                    believed_next = 1'b0;
                end
                screen_next = 1'b1;
            end
            OP_SCREEN_ON: begin
                if (!in_online_reg) begin
                    act_next      = ACT_UP;
                    since_next    = in_now_reg;
                    believed_next = 1'b1;
                end
                screen_next = 1'b0;
            end
            OP_DISABLE: begin
                mode_next     = MODE_DISABLED;
                since_next    = in_now_reg;
                believed_next = 1'b1;
                act_next      = ACT_UP;
            end
            OP_ENABLE: begin
                mode_next   = MODE_IDLE;
                resync_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            first_reg     <= 1'b1;
            dwell_reg     <= '0;
            last_reg      <= '0;
            believed_reg  <= 1'b1;
            since_reg     <= '0;
            screen_reg    <= 1'b0;
            resync_reg    <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (adv) begin
                mode_reg     <= mode_next;
                first_reg    <= first_next;
                dwell_reg    <= dwell_next;
                last_reg     <= last_next;
                believed_reg <= believed_next;
                since_reg    <= since_next;
                screen_reg   <= screen_next;
                resync_reg   <= resync_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg     <= s_tuser[2:0];
            in_now_reg    <= s_tdata[31:0];
            in_depth_reg  <= s_tdata[41:32];
            in_online_reg <= s_tdata[42];
        end
        if (adv) begin
            out_decision_reg <= mode_next;
            out_action_reg   <= act_next;
            out_pause_reg    <= pause_next;
            out_dur_reg      <= dur_next;
        end
    end

    `ASSERT_ALWAYS(a_pause_only_with_pause, aclk, aresetn, !out_valid_reg || out_action_reg == ACT_PAUSE || out_pause_reg == 16'd0)
    `ASSERT_ALWAYS(a_dur_only_with_down, aclk, aresetn, !out_valid_reg || out_action_reg == ACT_DOWN || out_dur_reg == 32'd0)
    `ASSERT_PROP(a_disable_sticks, aclk, aresetn, (adv && in_op_reg == OP_DISABLE) |=> (mode_reg == MODE_DISABLED && out_action_reg == ACT_UP))
    `ASSERT_PROP(a_result_follows_input, aclk, aresetn, adv |=> out_valid_reg)

endmodule

FILE: rtl/core_hotplug_load_governor_core.sv
`timescale 1ns / 1ps
// An input transfer loads the input registers; the result register loads from them when free.
// Throughput: one event per cycle unless m_tready stalls; the registers decouple the streams.
// The governor state update is a single subtract, saturating add and compare pass per event.
// Reset: aresetn is synchronous, active low; it restores the register defaults and the idle state.
// No clearing pass is needed after reset; the block accepts events in the next cycle.

module core_hotplug_load_governor_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_ms[31:0], run_queue_depth[41:32], core_is_online[42], zero fill[47:43]
    input  logic [hlg_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[2:0]
    input  logic [hlg_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // decision[1:0], action[3:2], pause_duration_ms[19:4],
    // online_duration_ms[51:20], zero fill[55:52]
    output logic [hlg_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hlg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hlg_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hlg_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import hlg_pkg::*;

    cfg_t cfg;

    hlg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hlg_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: sim/core_hotplug_load_governor_core_test.sv
`timescale 1ns / 1ps

module core_hotplug_load_governor_core_test;
    import hlg_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned N_PHASES = 8;
    localparam int unsigned PHASE_EVENTS = 50;
    localparam int N_DIRECTED = 27;

    typedef struct packed {
        mode_t       decision;
        act_t        action;
        logic [15:0] pause_ms;
        logic [31:0] online_ms;
    } gov_result_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now;
        logic [9:0]  depth;
        logic        online;
        logic        typed;
        mode_t       dec;
        act_t        act;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    core_hotplug_load_governor_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cfg_t        cfg = '{RST_START_DELAY, RST_UP_QUEUE, RST_DOWN_QUEUE, RST_UP_TIME,
                         RST_DOWN_TIME, RST_PAUSE, RST_SCREEN_OFF};
    mode_t       gov_mode = MODE_IDLE;
    logic        first_poll = 1'b1;
    logic [31:0] dwell_ms = '0;
    logic [31:0] last_poll_ms = '0;
    logic        believed_up = 1'b1;
    logic [31:0] since_ms = '0;
    logic        screen_dark = 1'b0;
    logic        resync_due = 1'b0;

    gov_result_t pending_decisions[$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned ready_hold = 0;
    logic        no_gaps = 1'b0;
    logic        core_real = 1'b1;
    logic [31:0] clock_ms = '0;

    logic                 in_fire = 1'b0;
    logic                 out_fire = 1'b0;
    logic                 apb_fire = 1'b0;
    logic [M_TDATA_W-1:0] out_data = '0;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{OP_POLL,       32'd0,          10'd0,    1'b1, 1'b1, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd70000,      10'd1023, 1'b0, 1'b1, MODE_IDLE,     ACT_NONE},
        '{3'd5,          32'd1,          10'd0,    1'b0, 1'b1, MODE_IDLE,     ACT_NONE},
        '{3'd6,          32'd2,          10'd1023, 1'b1, 1'b1, MODE_IDLE,     ACT_NONE},
        '{3'd7,          32'hFFFF_FFFF,  10'd1023, 1'b1, 1'b1, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd70001,      10'd1023, 1'b0, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd70300,      10'd1023, 1'b0, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd70301,      10'd1023, 1'b0, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd70600,      10'd1023, 1'b0, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd70700,      10'd20,   1'b1, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd70800,      10'd0,    1'b1, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd71100,      10'd0,    1'b1, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd71200,      10'd0,    1'b0, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_SCREEN_OFF, 32'd71250,      10'd0,    1'b1, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd71260,      10'd1023, 1'b0, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_SCREEN_ON,  32'd71300,      10'd0,    1'b0, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd71500,      10'd0,    1'b0, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd71600,      10'd0,    1'b1, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_DISABLE,    32'd71700,      10'd0,    1'b1, 1'b1, MODE_DISABLED, ACT_UP},
        '{OP_POLL,       32'd71800,      10'd0,    1'b0, 1'b1, MODE_DISABLED, ACT_NONE},
        '{OP_DISABLE,    32'd71900,      10'd1023, 1'b0, 1'b1, MODE_DISABLED, ACT_UP},
        '{OP_ENABLE,     32'd72000,      10'd0,    1'b1, 1'b1, MODE_IDLE,     ACT_NONE},
        '{OP_ENABLE,     32'd72100,      10'd0,    1'b1, 1'b1, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd80000,      10'd500,  1'b1, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd80100,      10'd0,    1'b1, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'd80099,      10'd0,    1'b1, 1'b0, MODE_IDLE,     ACT_NONE},
        '{OP_POLL,       32'hFFFF_FFFF,  10'd1023, 1'b0, 1'b0, MODE_IDLE,     ACT_NONE}
    };

    function automatic mode_t next_mode(input logic [31:0] now, input logic [9:0] depth,
                                        input logic two_cores);
        logic [31:0] elapsed;
        logic [32:0] sum;
        mode_t       nxt;
        elapsed = '0;
        nxt = MODE_IDLE;
        if (gov_mode == MODE_DISABLED) return MODE_DISABLED;
        if (now <= {12'd0, cfg.start_delay_ms}) return MODE_IDLE;
        if (first_poll) first_poll = 1'b0;
        else elapsed = now - last_poll_ms;
        sum = {1'b0, dwell_ms} + {1'b0, elapsed};
        dwell_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (!two_cores && depth >= cfg.up_queue_threshold) begin
            if (dwell_ms >= {16'd0, cfg.up_time_threshold}) nxt = MODE_UP;
        end else if (depth <= (two_cores ? cfg.down_queue_threshold : 10'd0)) begin
            if (dwell_ms >= (two_cores ? {16'd0, cfg.down_time_threshold} : 32'd0))
                nxt = MODE_DOWN;
        end else begin
            dwell_ms = '0;
        end
        if (nxt != MODE_IDLE) dwell_ms = '0;
        last_poll_ms = now;
        return nxt;
    endfunction

    function automatic gov_result_t governor_step(input logic [2:0] op, input logic [31:0] now,
                                                  input logic [9:0] depth, input logic actual);
        gov_result_t res;
        res.action = ACT_NONE;
        res.pause_ms = '0;
        res.online_ms = '0;
        case (op)
            OP_POLL: begin
                if (!screen_dark) begin
                    if (resync_due) begin
                        believed_up = actual;
                        resync_due = 1'b0;
                    end
                    gov_mode = next_mode(now, depth, actual);
                    if (gov_mode == MODE_DOWN) begin
                        if (believed_up && actual) begin
                            res.action = ACT_DOWN;
                            believed_up = 1'b0;
                            res.online_ms = now - since_ms;
                        end else if (believed_up != actual) begin
                            res.action = ACT_PAUSE;
                            res.pause_ms = cfg.pause_ms;
                            resync_due = 1'b1;
                        end
                    end else if (gov_mode == MODE_UP) begin
                        if (!believed_up && !actual) begin
                            res.action = ACT_UP;
                            believed_up = 1'b1;
                            since_ms = now;
                        end else if (believed_up != actual) begin
                            res.action = ACT_PAUSE;
                            res.pause_ms = cfg.pause_ms;
                            resync_due = 1'b1;
                        end
                    end
                end
            end
            OP_SCREEN_OFF: begin
                if (actual && cfg.screen_off_single_core) begin
                    res.action = ACT_DOWN;
                    believed_up = 1'b0;
                end
                screen_dark = 1'b1;
            end
            OP_SCREEN_ON: begin
                if (!actual) begin
                    res.action = ACT_UP;
                    since_ms = now;
                    believed_up = 1'b1;
                end
                screen_dark = 1'b0;
            end
            OP_DISABLE: begin
                gov_mode = MODE_DISABLED;
                since_ms = now;
                believed_up = 1'b1;
                res.action = ACT_UP;
            end
            OP_ENABLE: begin
                gov_mode = MODE_IDLE;
                resync_due = 1'b1;
            end
            default: begin
            end
        endcase
        res.decision = gov_mode;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_setting(input int unsigned phase,
                                                 input logic [31:0] top,
                                                 input logic [31:0] typical);
        if (phase == 0) return '0;
        if (phase == 1) return top;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return top;
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    function automatic logic [9:0] depth_near(input logic [9:0] level);
        int d;
        d = int'(level) + int'($urandom_range(0, 4)) - 2;
        if (d < 0) d = 0;
        if (d > 1023) d = 1023;
        return 10'(d);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(negedge aclk) begin
        in_fire = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        apb_fire = psel && penable && pwrite && pready;
        out_data = m_tdata;
    end

    always @(posedge aclk) begin : result_side
        gov_result_t want;
        int unsigned g;
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
            m_tready <= 1'b0;
        end else begin
            g = pick_gap();
            m_tready <= (g == 0);
            ready_hold = (g == 0) ? 0 : g - 1;
        end
        if (out_fire) begin
            if (pending_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transfer with nothing outstanding: %h", out_data);
            end else begin
                want = pending_decisions.pop_front();
                if (out_data[1:0] != want.decision)
                    note_mismatch("decision", want.decision, out_data[1:0]);
                if (out_data[3:2] != want.action)
                    note_mismatch("action", want.action, out_data[3:2]);
                if (out_data[19:4] != want.pause_ms)
                    note_mismatch("pause_duration_ms", want.pause_ms, out_data[19:4]);
                if (out_data[51:20] != want.online_ms)
                    note_mismatch("online_duration_ms", want.online_ms, out_data[51:20]);
            end
        end
    end

    always @(posedge aclk) begin
        if (in_fire || out_fire || apb_fire || !aresetn) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("core_hotplug_load_governor_core_test: errors");
            $finish;
        end
    end

    task automatic send_event(input logic [2:0] op, input logic [31:0] now,
                              input logic [9:0] depth, input logic online, input logic typed,
                              input mode_t want_mode, input act_t want_act);
        gov_result_t res;
        gov_result_t fixed;
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'd0, online, depth, now};
        do @(posedge aclk); while (!in_fire);
        res = governor_step(op, now, depth, online);
        if (res.action == ACT_UP && $urandom_range(0, 9) != 0) core_real = 1'b1;
        else if (res.action == ACT_DOWN && $urandom_range(0, 9) != 0) core_real = 1'b0;
        if (typed) begin
            fixed = '{want_mode, want_act, 16'd0, 32'd0};
            pending_decisions.push_back(fixed);
        end else begin
            pending_decisions.push_back(res);
        end
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic random_event();
        logic [2:0]  op;
        logic [31:0] step;
        logic [9:0]  depth;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (screen_dark && r < 30) begin
            op = OP_SCREEN_ON;
        end else if (gov_mode == MODE_DISABLED && r < 30) begin
            op = OP_ENABLE;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 80) op = OP_POLL;
            else if (r < 84) op = OP_SCREEN_OFF;
            else if (r < 87) op = OP_SCREEN_ON;
            else if (r < 90) op = OP_DISABLE;
            else if (r < 96) op = OP_ENABLE;
            else op = 3'($urandom_range(5, 7));
        end
        step = ($urandom_range(0, 99) < 3) ? $urandom() : $urandom_range(0, 400);
        clock_ms = clock_ms + step;
        r = $urandom_range(0, 99);
        if (r < 30) depth = depth_near(cfg.up_queue_threshold);
        else if (r < 60) depth = depth_near(cfg.down_queue_threshold);
        else if (r < 75) depth = '0;
        else if (r < 80) depth = 10'd1023;
        else depth = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 99) < 4) core_real = ~core_real;
        send_event(op, clock_ms, depth, core_real, 1'b0, MODE_IDLE, ACT_NONE);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!apb_fire);
        case (idx)
            REG_START_DELAY: cfg.start_delay_ms = val[19:0];
            REG_UP_QUEUE:    cfg.up_queue_threshold = val[9:0];
            REG_DOWN_QUEUE:  cfg.down_queue_threshold = val[9:0];
            REG_UP_TIME:     cfg.up_time_threshold = val[15:0];
            REG_DOWN_TIME:   cfg.down_time_threshold = val[15:0];
            REG_PAUSE:       cfg.pause_ms = val[15:0];
            REG_SCREEN_OFF:  cfg.screen_off_single_core = val[0];
            default: begin
            end
        endcase
    endtask

    task automatic configure_phase(input int unsigned phase);
        cfg_write(REG_START_DELAY, pick_setting(phase, 32'hF_FFFF, 32'd5000));
        cfg_write(REG_UP_QUEUE, pick_setting(phase, 32'd1023, 32'd40));
        cfg_write(REG_DOWN_QUEUE, pick_setting(phase, 32'd1023, 32'd10));
        cfg_write(REG_UP_TIME, pick_setting(phase, 32'd65535, 32'd1500));
        cfg_write(REG_DOWN_TIME, pick_setting(phase, 32'd65535, 32'd1500));
        cfg_write(REG_PAUSE, pick_setting(phase, 32'd65535, 32'd65535));
        cfg_write(REG_SCREEN_OFF, pick_setting(phase, 32'd1, 32'd1));
        psel <= 1'b0;
        penable <= 1'b0;
        // Start each phase within 200 ms either side of the start delay so that it is crossed early.
        clock_ms = {12'd0, cfg.start_delay_ms} + $urandom_range(0, 400) - 32'd200;
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_event(directed_rows[i].op, directed_rows[i].now, directed_rows[i].depth,
                       directed_rows[i].online, directed_rows[i].typed,
                       directed_rows[i].dec, directed_rows[i].act);
        end
        settle();
        for (phase = 0; phase < N_PHASES; phase++) begin
            configure_phase(phase);
            no_gaps = (phase == 3);
            for (n = 0; n < PHASE_EVENTS; n++) random_event();
            settle();
        end
        repeat (8) @(posedge aclk);
        mismatches += pending_decisions.size();
        if (mismatches == 0) begin
            $display("core_hotplug_load_governor_core_test: clean");
        end else begin
            $display("core_hotplug_load_governor_core_test: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hlg_pkg.sv
rtl/hlg_cfg_regs.sv
rtl/hlg_core.sv
rtl/core_hotplug_load_governor_core.sv
sim/core_hotplug_load_governor_core_test.sv
